/* hdl/wta_pkg.sv */
// Package for the windowed three-axis average block.
// Holds the widths, event codes and helper functions shared by the top level and the divider.
// No dependencies.
package wta_pkg;

	// field and state widths
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned TS_W     = 64;
	localparam int unsigned WIN_W    = 40;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned CNT_W    = 16;

	// divider geometry: a full pass works through the whole dividend, a short
	// pass only through the low SUM_W bits (the sums never need more)
	localparam int unsigned DVD_W      = TS_W;
	localparam int unsigned DSR_W      = WIN_W;
	localparam int unsigned LONG_ITER  = DVD_W;
	localparam int unsigned SHORT_ITER = SUM_W;
	localparam int unsigned ITER_W     = $clog2(LONG_ITER + 1);
	localparam int unsigned PAD_W      = DVD_W - SHORT_ITER;

	// sample count cap: the smaller of the sample limit and the count range
	localparam longint unsigned MAX_SAMPLES = 64'd65535;
	localparam longint unsigned CNT_RANGE   = (64'd1 << CNT_W) - 64'd1;
	localparam logic [CNT_W-1:0] COUNT_LIMIT =
		CNT_W'((MAX_SAMPLES < CNT_RANGE) ? MAX_SAMPLES : CNT_RANGE);

	// window length after reset
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(64'd500000000);

	// request types
	localparam logic [1:0] REQ_VALUE = 2'd0;
	localparam logic [1:0] REQ_SYNC  = 2'd1;

	// value event codes
	localparam logic [2:0] CODE_X   = 3'd0;
	localparam logic [2:0] CODE_Y   = 3'd1;
	localparam logic [2:0] CODE_Z   = 3'd2;
	localparam logic [2:0] CODE_THI = 3'd3;
	localparam logic [2:0] CODE_TLO = 3'd4;

	// divider launch request
	typedef struct packed {
		logic start;
		logic short_op;
	} div_req_t;

	// magnitude of a signed sum
	function automatic logic [SUM_W-1:0] sum_abs(input logic [SUM_W-1:0] s);
		sum_abs = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
	endfunction

	// signed mean from an unsigned quotient, truncated toward zero
	function automatic logic [VAL_W-1:0] mean_sign(input logic [VAL_W-1:0] q, input logic neg);
		mean_sign = neg ? (~q + VAL_W'(1)) : q;
	endfunction

endpackage

/* hdl/wta_divider.sv */
// Shared unsigned restoring divider, one quotient bit per cycle.
// Used for the window index and for the three means.
// Depends on wta_pkg.
module wta_divider import wta_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;

	logic [DSR_W:0]    trial;
	logic              fits;
	logic [DSR_W:0]    diff;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = (trial >= {1'b0, dsr_q});
		diff  = trial - {1'b0, dsr_q};
	end

	// control: busy flag, iteration count, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= req.short_op ? ITER_W'(SHORT_ITER) : ITER_W'(LONG_ITER);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.short_op ? {dividend[SHORT_ITER-1:0], {PAD_W{1'b0}}} : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* hdl/windowed_three_axis_average.sv */
// Windowed three-axis average, top level.
// Event latching, window sequencer, sums and the output register; uses wta_divider.
// Depends on wta_pkg and wta_divider.

// A value event is taken directly while idle. A sync event runs the shared bit-serial divider to get
// the window index (timestamp / window_ns, a full pass over the dividend). When the
// window changes with samples pending, the same divider then works out the x, y and z means
// (a short pass each), and the result then moves to the output register once the previous
// result has been taken. in_ready is low while a
// sync is in work.
// cfg_window_ns may be written at any time the block is idle; zero acts as one.
module windowed_three_axis_average import wta_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [WIN_W-1:0]        cfg_window_ns,
	// events
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [2:0]              event_code,
	input  logic signed [VAL_W-1:0] event_value,
	// results
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] mean_x,
	output logic signed [VAL_W-1:0] mean_y,
	output logic signed [VAL_W-1:0] mean_z,
	output logic [CNT_W-1:0]        sample_total,
	output logic                    count_saturated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_MEAN_X,
		ST_MEAN_Y,
		ST_MEAN_Z,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [WIN_W-1:0]  window_q;
	logic [VAL_W-1:0]  lat_x_q, lat_y_q, lat_z_q;
	logic [TS_W-1:0]   ts_q;
	logic [TS_W-1:0]   prev_win_q;
	logic [SUM_W-1:0]  sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [VAL_W-1:0]  mx_q, my_q, mz_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  out_x_q, out_y_q, out_z_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_sat_q;

	logic              in_fire;
	logic              sync_fire;
	logic              win_change;
	logic              out_free;
	div_req_t          div_req;
	logic [DVD_W-1:0]  div_dividend;
	logic [DSR_W-1:0]  div_divisor;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;
	logic [WIN_W-1:0]  win_eff;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign sync_fire = in_fire && (req_type == REQ_SYNC);
	assign win_change = (div_quot != prev_win_q);
	assign out_free  = !out_valid_q || out_ready;
	assign win_eff   = (window_q == '0) ? WIN_W'(1) : window_q;

	// divider launch and operand selection
	always_comb begin
		div_req.start    = 1'b0;
		div_req.short_op = 1'b1;
		div_dividend     = {{PAD_W{1'b0}}, sum_abs(sum_z_q)};
		div_divisor      = DSR_W'(count_q);
		unique case (state_q)
			ST_IDLE: begin
				div_req.start    = sync_fire;
				div_req.short_op = 1'b0;
				div_dividend     = ts_q;
				div_divisor      = win_eff;
			end
			ST_WIN: begin
				div_req.start = div_done && win_change && (count_q != '0);
				div_dividend  = {{PAD_W{1'b0}}, sum_abs(sum_x_q)};
			end
			ST_MEAN_X: begin
				div_req.start = div_done;
				div_dividend  = {{PAD_W{1'b0}}, sum_abs(sum_y_q)};
			end
			ST_MEAN_Y: begin
				div_req.start = div_done;
			end
			default: begin
			end
		endcase
	end

	wta_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer, event state and window accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WINDOW_RESET;
			lat_x_q    <= '0;
			lat_y_q    <= '0;
			lat_z_q    <= '0;
			ts_q       <= '0;
			prev_win_q <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			sum_z_q    <= '0;
			count_q    <= '0;
			drop_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_window_ns;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (req_type == REQ_VALUE)) begin
						unique case (event_code)
							CODE_X:   lat_x_q <= event_value;
							CODE_Y:   lat_y_q <= event_value;
							CODE_Z:   lat_z_q <= event_value;
							CODE_THI: ts_q    <= ts_q | {event_value, {VAL_W{1'b0}}};
							CODE_TLO: ts_q    <= ts_q | {{VAL_W{1'b0}}, event_value};
							default: begin
							end
						endcase
					end else if (sync_fire) begin
						// divider has taken the timestamp at this edge
						ts_q    <= '0;
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (div_done) begin
						if (!win_change) begin
							// same window: add latched sample or flag the drop
							if (count_q < COUNT_LIMIT) begin
								sum_x_q <= sum_x_q + {{(SUM_W-VAL_W){lat_x_q[VAL_W-1]}}, lat_x_q};
								sum_y_q <= sum_y_q + {{(SUM_W-VAL_W){lat_y_q[VAL_W-1]}}, lat_y_q};
								sum_z_q <= sum_z_q + {{(SUM_W-VAL_W){lat_z_q[VAL_W-1]}}, lat_z_q};
								count_q <= count_q + CNT_W'(1);
							end else begin
								drop_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end else begin
							prev_win_q <= div_quot;
							if (count_q != '0) begin
								state_q <= ST_MEAN_X;
							end else begin
								// empty window: just clear
								lat_x_q <= '0;
								lat_y_q <= '0;
								lat_z_q <= '0;
								sum_x_q <= '0;
								sum_y_q <= '0;
								sum_z_q <= '0;
								drop_q  <= 1'b0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_MEAN_X: begin
					if (div_done) begin
						state_q <= ST_MEAN_Y;
					end
				end
				ST_MEAN_Y: begin
					if (div_done) begin
						state_q <= ST_MEAN_Z;
					end
				end
				ST_MEAN_Z: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// result moves to the output register, window state clears
					if (out_free) begin
						lat_x_q <= '0;
						lat_y_q <= '0;
						lat_z_q <= '0;
						sum_x_q <= '0;
						sum_y_q <= '0;
						sum_z_q <= '0;
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// mean capture as each division finishes
	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (state_q)
				ST_MEAN_X: mx_q <= mean_sign(div_quot[VAL_W-1:0], sum_x_q[SUM_W-1]);
				ST_MEAN_Y: my_q <= mean_sign(div_quot[VAL_W-1:0], sum_y_q[SUM_W-1]);
				ST_MEAN_Z: mz_q <= mean_sign(div_quot[VAL_W-1:0], sum_z_q[SUM_W-1]);
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_x_q   <= mx_q;
			out_y_q   <= my_q;
			out_z_q   <= mz_q;
			out_cnt_q <= count_q;
			out_sat_q <= drop_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mean_x          = out_x_q;
	assign mean_y          = out_y_q;
	assign mean_z          = out_z_q;
	assign sample_total    = out_cnt_q;
	assign count_saturated = out_sat_q;

	// divider only finishes while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WIN || state_q == ST_MEAN_X ||
		              state_q == ST_MEAN_Y || state_q == ST_MEAN_Z))
		else $error("divider finished outside a wait state");

	// a new result always covers at least one sample
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (sample_total != '0))
		else $error("result emitted for an empty window");

	// an empty window carries no sums
	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |->
		(sum_x_q == '0 && sum_y_q == '0 && sum_z_q == '0))
		else $error("sums nonzero with zero sample count");

	// count never passes its cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_LIMIT)
		else $error("sample count above limit");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for windowed_three_axis_average: directed and random accelerometer event streams,
// with each window result checked against a cycle-free predictor of the three means.
// Depends on wta_pkg and the windowed_three_axis_average RTL.
module testbench;
	import wta_pkg::*;

	localparam int unsigned LIMIT_CYCLES  = 3_000_000;
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned HOLD_CYCLES   = 3000;
	localparam int unsigned PHASE_ITEMS   = 320;

	// request types and codes the block ignores
	localparam logic [1:0] REQ_OTHER  = 2'd2;
	localparam logic [1:0] REQ_SPARE  = 2'd3;
	localparam logic [2:0] CODE_NONE  = 3'd5;
	localparam logic [2:0] CODE_SPARE = 3'd7;

	typedef struct packed {
		logic [1:0]       kind;
		logic [2:0]       code;
		logic [VAL_W-1:0] value;
	} sensor_event_t;

	typedef struct packed {
		logic [VAL_W-1:0] mx;
		logic [VAL_W-1:0] my;
		logic [VAL_W-1:0] mz;
		logic [CNT_W-1:0] total;
		logic             sat;
	} window_means_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// DUT ports
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [WIN_W-1:0]        cfg_window_ns = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              req_type = '0;
	logic [2:0]              event_code = '0;
	logic signed [VAL_W-1:0] event_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] mean_x, mean_y, mean_z;
	logic [CNT_W-1:0]        sample_total;
	logic                    count_saturated;

	windowed_three_axis_average i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_window_ns   (cfg_window_ns),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.event_code      (event_code),
		.event_value     (event_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mean_x          (mean_x),
		.mean_y          (mean_y),
		.mean_z          (mean_z),
		.sample_total    (sample_total),
		.count_saturated (count_saturated)
	);

	// run bookkeeping
	sensor_event_t pending_events[$];
	window_means_t expected_means[$];
	int unsigned   send_idle_pct = 0;
	int unsigned   stall_pct = 0;
	int unsigned   errors = 0;
	int unsigned   events_taken = 0;
	int unsigned   means_checked = 0;
	int unsigned   queued_items = 0;
	int unsigned   cycle_count = 0;
	int unsigned   window_settings = 0;
	logic          in_taken = 1'b0;
	logic          hold_request = 1'b0;
	logic          hold_taken = 1'b0;
	int unsigned   hold_remaining = 0;

	// predictor state
	logic [WIN_W-1:0]        win_len = WINDOW_RESET;
	logic signed [VAL_W-1:0] lat_x = '0, lat_y = '0, lat_z = '0;
	logic [TS_W-1:0]         stamp = '0;
	logic [TS_W-1:0]         cur_window = '0;
	longint                  acc_x = 0, acc_y = 0, acc_z = 0;
	longint                  n_samples = 0;
	logic                    overflowed = 1'b0;

	// mean of a window sum, truncated toward zero, low word kept
	function automatic logic [VAL_W-1:0] window_mean(input longint acc, input longint n);
		longint q;
		q = acc / n;
		return VAL_W'(q);
	endfunction

	// update the predicted state for one accepted event, queue any closed window
	function automatic void track_event(input sensor_event_t ev);
		logic [TS_W-1:0] divisor;
		logic [TS_W-1:0] idx;
		window_means_t   res;
		if (ev.kind == REQ_VALUE) begin
			case (ev.code)
				CODE_X:   lat_x = ev.value;
				CODE_Y:   lat_y = ev.value;
				CODE_Z:   lat_z = ev.value;
				CODE_THI: stamp |= {ev.value, {VAL_W{1'b0}}};
				CODE_TLO: stamp |= TS_W'(ev.value);
				default: ;
			endcase
		end else if (ev.kind == REQ_SYNC) begin
			divisor = (win_len == '0) ? TS_W'(1) : TS_W'(win_len);
			idx = stamp / divisor;
			if (idx != cur_window) begin
				if (n_samples != 0) begin
					res.mx    = window_mean(acc_x, n_samples);
					res.my    = window_mean(acc_y, n_samples);
					res.mz    = window_mean(acc_z, n_samples);
					res.total = CNT_W'(n_samples);
					res.sat   = overflowed;
					expected_means.push_back(res);
				end
				cur_window = idx;
				lat_x = '0;
				lat_y = '0;
				lat_z = '0;
				acc_x = 0;
				acc_y = 0;
				acc_z = 0;
				n_samples = 0;
				overflowed = 1'b0;
			end else if (n_samples < COUNT_LIMIT) begin
				acc_x += lat_x;
				acc_y += lat_y;
				acc_z += lat_z;
				n_samples++;
			end else begin
				overflowed = 1'b1;
			end
			stamp = '0;
		end
	endfunction

	// input transaction accepted: feed the predictor
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			track_event({req_type, event_code, event_value});
			events_taken++;
		end
	end

	// event driver
	always @(negedge clk) begin : drive_events
		sensor_event_t ev;
		if (!in_valid || in_taken) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ev = pending_events.pop_front();
				in_valid    <= 1'b1;
				req_type    <= ev.kind;
				event_code  <= ev.code;
				event_value <= ev.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, armed once per run
	always @(negedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_remaining <= HOLD_CYCLES;
			hold_taken     <= 1'b1;
		end else if (hold_remaining != 0) begin
			hold_remaining <= hold_remaining - 1;
		end
	end

	// result backpressure
	always @(negedge clk) begin
		out_ready <= (hold_remaining == 0) && ($urandom_range(99) >= stall_pct);
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin : check_means
		window_means_t want;
		if (out_valid && out_ready) begin
			if (expected_means.size() == 0) begin
				$display("%0t: result with no window close pending, expected none, got %h %h %h %0d %b",
					$time, mean_x, mean_y, mean_z, sample_total, count_saturated);
				errors++;
			end else begin
				want = expected_means.pop_front();
				check_field("mean_x", want.mx, mean_x);
				check_field("mean_y", want.my, mean_y);
				check_field("mean_z", want.mz, mean_z);
				check_field("sample_total", VAL_W'(want.total), VAL_W'(sample_total));
				check_field("count_saturated", VAL_W'(want.sat), VAL_W'(count_saturated));
				means_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus helpers
	function automatic void push_event(input logic [1:0] kind, input logic [2:0] code,
			input logic [VAL_W-1:0] value);
		sensor_event_t ev;
		ev.kind  = kind;
		ev.code  = code;
		ev.value = value;
		pending_events.push_back(ev);
		if (kind == REQ_SYNC || (kind == REQ_VALUE && code <= CODE_TLO))
			queued_items++;
	endfunction

	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 19))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [TS_W-1:0] rand_wide();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [TS_W-1:0] pick_stamp();
		case ($urandom_range(0, 2))
			0: return TS_W'($urandom_range(0, 3000));
			1: return rand_wide() >> $urandom_range(0, 63);
			default: return rand_wide();
		endcase
	endfunction

	// latch x, y and z in a rotated order, sometimes leaving some out
	function automatic void queue_axes();
		logic [2:0] axis_codes[3];
		int unsigned rot;
		axis_codes[0] = CODE_X;
		axis_codes[1] = CODE_Y;
		axis_codes[2] = CODE_Z;
		rot = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++)
			if ($urandom_range(0, 99) >= 15)
				push_event(REQ_VALUE, axis_codes[(rot + i) % 3], rand_word());
	endfunction

	// time words in either order; zero words often skipped, some repeated
	function automatic void queue_stamp(input logic [TS_W-1:0] ts);
		logic send_hi, send_lo, hi_first;
		send_hi  = (ts[TS_W-1:VAL_W] != '0) || $urandom_range(0, 1);
		send_lo  = (ts[VAL_W-1:0] != '0) || $urandom_range(0, 1);
		hi_first = $urandom_range(0, 1);
		if (send_hi && hi_first)
			push_event(REQ_VALUE, CODE_THI, ts[TS_W-1:VAL_W]);
		if (send_lo)
			push_event(REQ_VALUE, CODE_TLO, ts[VAL_W-1:0]);
		if (send_hi && !hi_first)
			push_event(REQ_VALUE, CODE_THI, ts[TS_W-1:VAL_W]);
		if ($urandom_range(0, 9) == 0)
			push_event(REQ_VALUE, CODE_TLO, ts[VAL_W-1:0] & $urandom);
	endfunction

	// one window: an opening sync that normally opens a new window, then one to six samples in it
	function automatic void queue_window(input logic [TS_W-1:0] span);
		logic [TS_W-1:0] base;
		int unsigned     n;
		n = $urandom_range(1, 6);
		base = pick_stamp();
		base = base - base % span;
		for (int k = 0; k <= n; k++) begin
			if (k > 0 || $urandom_range(0, 3) == 0)
				queue_axes();
			queue_stamp(base + rand_wide() % span);
			push_event(REQ_SYNC, 3'($urandom_range(0, 7)), $urandom);
		end
	endfunction

	function automatic void queue_noise();
		push_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_word());
	endfunction

	// block must be idle before a register write
	task automatic drain();
		do @(posedge clk);
		while (pending_events.size() != 0 || in_valid || expected_means.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] len);
		@(negedge clk);
		cfg_valid     <= 1'b1;
		cfg_window_ns <= len;
		do @(posedge clk);
		while (!cfg_ready);
		win_len = len;
		window_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [WIN_W-1:0] len, input int unsigned send_pct,
			input int unsigned recv_pct, input bit with_hold);
		logic [TS_W-1:0] span;
		set_window(len);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
		span = (len == '0) ? TS_W'(1) : TS_W'(len);
		queued_items = 0;
		while (queued_items < PHASE_ITEMS) begin
			queue_window(span);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) queue_noise();
		end
		if (with_hold)
			hold_request = 1'b1;
		drain();
	endtask

	// main sequence
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, truncation toward zero, ignored events, OR of time words,
		// empty window, all under the reset window length
		push_event(REQ_VALUE, CODE_X, 32'h7FFF_FFFF);
		push_event(REQ_VALUE, CODE_Y, 32'h8000_0000);
		push_event(REQ_VALUE, CODE_Z, 32'hFFFF_FFFF);
		push_event(REQ_SYNC, CODE_X, '0);
		push_event(REQ_VALUE, CODE_X, 32'h8000_0000);
		push_event(REQ_VALUE, CODE_Y, 32'h7FFF_FFFF);
		push_event(REQ_VALUE, CODE_Z, '0);
		push_event(REQ_VALUE, CODE_TLO, 32'd499_999_999);
		push_event(REQ_SYNC, CODE_SPARE, '1);
		push_event(REQ_OTHER, CODE_X, 32'd5);
		push_event(REQ_SPARE, CODE_THI, '1);
		push_event(REQ_VALUE, CODE_NONE, '1);
		push_event(REQ_VALUE, CODE_SPARE, '1);
		push_event(REQ_VALUE, CODE_THI, '1);
		push_event(REQ_VALUE, CODE_TLO, 32'h0000_FFFF);
		push_event(REQ_VALUE, CODE_TLO, 32'hFFFF_0000);
		push_event(REQ_SYNC, CODE_X, '0);
		push_event(REQ_SYNC, CODE_X, '0);
		push_event(REQ_VALUE, CODE_X, -32'sd7);
		push_event(REQ_VALUE, CODE_Y, 32'sd7);
		push_event(REQ_VALUE, CODE_Z, 32'h8000_0000);
		push_event(REQ_SYNC, CODE_X, '0);
		push_event(REQ_VALUE, CODE_X, -32'sd8);
		push_event(REQ_SYNC, CODE_X, '0);
		push_event(REQ_VALUE, CODE_THI, 32'd1);
		push_event(REQ_SYNC, CODE_X, '0);
		drain();

		// random phases across window lengths and idle patterns
		run_phase(40'd1, 0, 0, 1'b0);
		run_phase('1, 55, 0, 1'b0);
		run_phase('0, 0, 55, 1'b0);
		run_phase(WIN_W'($urandom_range(1000, 1_000_000_000)), 38, 38, 1'b0);
		run_phase(WINDOW_RESET, 0, 0, 1'b1);
		run_phase({8'($urandom_range(0, 255)), 32'($urandom)}, 38, 38, 1'b0);

		$display("Run covered %0d events and %0d window results over %0d window lengths,",
			events_taken, means_checked, window_settings);
		$display("including unit, zero, full-scale and reset lengths and a long output stall.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
